### hw/rtl/rtp_nack_list_generator_defines.svh
// Assertion macros used by the checker file.
`ifndef RTP_NACK_LIST_GENERATOR_DEFINES_SVH
`define RTP_NACK_LIST_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define RNLG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rnlg check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define RNLG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rnlg check failed");

`endif

### hw/rtl/rnlg_pkg.sv
// ----------------------------------------------------------------------------
// rnlg_pkg
// Types and fixed constants of the NACK list generator.
// ----------------------------------------------------------------------------
package rnlg_pkg;

  localparam int SEQ_W       = 16;
  localparam int TIME_W      = 32;
  localparam int RETRY_W     = 8;
  localparam int MODE_W      = 2;
  localparam int AGE_W       = 16;
  localparam int ENT_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int MAX_RESULTS = 64;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  // input mode codes
  localparam logic [MODE_W-1:0] MODE_ARRIVE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BATCH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RTT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd3;

  localparam logic [SEQ_W-1:0]   RST_RTT     = 16'd100;
  localparam logic [RETRY_W-1:0] RST_RETRIES = 8'd20;
  localparam logic [AGE_W-1:0]   RST_AGE     = 16'd10000;
  localparam logic [ENT_W-1:0]   RST_ENTRIES = 7'd64;

  typedef enum logic [1:0] {
    OP_ARRIVE,
    OP_BATCH,
    OP_CLEAR,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   rtt_ms;
    logic [RETRY_W-1:0] max_retries;
    logic [AGE_W-1:0]   max_packet_age;
    logic [ENT_W-1:0]   max_entries;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [RETRY_W-1:0] retries;
    logic [TIME_W-1:0]  sent_at;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_PURGE,
    ST_PCHK,
    ST_INSERT,
    ST_SEL,
    ST_UPD,
    ST_SDONE,
    ST_EMIT
  } state_t;

endpackage

### hw/rtl/rnlg_ram.sv
// ----------------------------------------------------------------------------
// rnlg_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rnlg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/rnlg_front.sv
// ----------------------------------------------------------------------------
// rnlg_front
// Takes input words, decodes the mode and queues commands (two deep).
// ----------------------------------------------------------------------------
module rnlg_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rnlg_pkg::MODE_W-1:0]  in_mode,
  input  logic [rnlg_pkg::SEQ_W-1:0]   in_seq,
  input  logic [rnlg_pkg::TIME_W-1:0]  in_now_ms,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output rnlg_pkg::cmd_t               cmd
);

  rnlg_pkg::cmd_t q_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;
  rnlg_pkg::cmd_t dec;

  always_comb begin
    dec.seq    = in_seq;
    dec.now_ms = in_now_ms;
    unique case (in_mode)
      rnlg_pkg::MODE_ARRIVE: dec.op = rnlg_pkg::OP_ARRIVE;
      rnlg_pkg::MODE_BATCH:  dec.op = rnlg_pkg::OP_BATCH;
      rnlg_pkg::MODE_CLEAR:  dec.op = rnlg_pkg::OP_CLEAR;
      default:               dec.op = rnlg_pkg::OP_IGNORE;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

### hw/rtl/rnlg_back.sv
// ----------------------------------------------------------------------------
// rnlg_back
// Table engine: sweeps the entry RAM for lookups, purge and batch selection,
// writes inserted entries, and drives the result register.
// ----------------------------------------------------------------------------
module rnlg_back #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rnlg_pkg::cfg_t              cfg,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  rnlg_pkg::cmd_t              cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_recovered,
  output logic                        out_nack_valid,
  output logic [rnlg_pkg::SEQ_W-1:0]  out_nack_seq,
  output logic                        out_last
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_W = rnlg_pkg::SEQ_W + 1;
  localparam int SW    = rnlg_pkg::SEQ_W;
  localparam int TW    = rnlg_pkg::TIME_W;
  localparam int RW    = rnlg_pkg::RETRY_W;
  localparam int EW    = $bits(rnlg_pkg::entry_t);

  function automatic logic seq_lower(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW-1:0] dba;
    logic [SW-1:0] dab;
    dba = b - a;
    dab = a - b;
    return ((b > a) && !dba[SW-1]) || ((a > b) && dab[SW-1]);
  endfunction

  rnlg_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [SW-1:0]          seq_r, seq_nxt;
  logic [TW-1:0]          now_r, now_nxt;
  logic                   started_r, started_nxt;
  logic [SW-1:0]          last_seq_r, last_seq_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [TABLE_DEPTH-1:0] present_r, present_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   pv_r, pv_nxt;
  logic [AW-1:0]          pidx_r, pidx_nxt;
  logic                   found_r, found_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          slot_r, slot_nxt;
  logic [CW-1:0]          d_r, d_nxt;
  logic                   best_any_r, best_any_nxt;
  logic [AW-1:0]          best_idx_r, best_idx_nxt;
  logic [SW-1:0]          best_seq_r, best_seq_nxt;
  logic [RW-1:0]          best_ret_r, best_ret_nxt;
  logic                   prev_any_r, prev_any_nxt;
  logic [SW-1:0]          prev_r, prev_nxt;
  logic [rnlg_pkg::RES_W-1:0] nres_r, nres_nxt;
  logic                   pend_r, pend_nxt;
  logic [SW-1:0]          pend_seq_r, pend_seq_nxt;
  logic                   r_rec_r, r_rec_nxt;
  logic                   r_nv_r, r_nv_nxt;
  logic [SW-1:0]          r_seq_r, r_seq_nxt;
  logic                   r_last_r, r_last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   o_rec_r, o_rec_nxt;
  logic                   o_nv_r, o_nv_nxt;
  logic [SW-1:0]          o_seq_r, o_seq_nxt;
  logic                   o_last_r, o_last_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  rnlg_pkg::entry_t       ram_wdata;
  rnlg_pkg::entry_t       ent;
  logic [EW-1:0]          ram_rdata;

  logic                   sweep_st, rd_issue, sweep_last, out_free, take;
  logic                   ent_valid, hit, due, better, overflow, last_res;
  logic [SW-1:0]          first_seq, floor_seq, gap, seq_off;
  logic [SUM_W-1:0]       limit;
  logic [RW-1:0]          ret_new;

  rnlg_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (ram_rdata)
  );

  assign ent        = rnlg_pkg::entry_t'(ram_rdata);
  assign sweep_st   = (state_r == rnlg_pkg::ST_FIND) || (state_r == rnlg_pkg::ST_PURGE) ||
                      (state_r == rnlg_pkg::ST_SEL);
  assign rd_issue   = sweep_st && (cnt_r < CW'(TABLE_DEPTH));
  assign sweep_last = pv_r && (pidx_r == AW'(TABLE_DEPTH - 1));
  assign out_free   = !out_valid_r || out_ready;
  assign cmd_ready  = (state_r == rnlg_pkg::ST_IDLE);
  assign take       = cmd_valid && cmd_ready;
  assign ent_valid  = pv_r && valid_r[pidx_r];
  assign hit        = ent_valid && (ent.seq == seq_r);
  assign first_seq  = last_seq_r + SW'(1);
  assign floor_seq  = seq_r - cfg.max_packet_age;
  assign gap        = seq_r - first_seq;
  assign seq_off    = ent.seq - first_seq;
  assign limit      = ({{(SUM_W - rnlg_pkg::ENT_W){1'b0}}, cfg.max_entries} >
                       SUM_W'(TABLE_DEPTH)) ? SUM_W'(TABLE_DEPTH) :
                      {{(SUM_W - rnlg_pkg::ENT_W){1'b0}}, cfg.max_entries};
  assign overflow   = ({1'b0, gap} + SUM_W'(count_r)) > limit;
  assign due        = ent_valid && (!prev_any_r || (ent.seq > prev_r)) &&
                      ((now_r - ent.sent_at) >= {{(TW - SW){1'b0}}, cfg.rtt_ms});
  assign better     = due && (!best_any_r || (ent.seq < best_seq_r));
  assign ret_new    = (best_ret_r == {RW{1'b1}}) ? best_ret_r : best_ret_r + RW'(1);
  assign last_res   = (nres_r + rnlg_pkg::RES_W'(1)) == rnlg_pkg::RES_W'(rnlg_pkg::MAX_RESULTS);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rnlg_pkg::ST_IDLE: begin
        if (take) begin
          unique case (cmd.op)
            rnlg_pkg::OP_ARRIVE: begin
              if (!started_r || (cmd.seq == last_seq_r)) begin
                state_nxt = rnlg_pkg::ST_EMIT;
              end else if (seq_lower(cmd.seq, last_seq_r)) begin
                state_nxt = rnlg_pkg::ST_FIND;
              end else begin
                state_nxt = rnlg_pkg::ST_PURGE;
              end
            end
            rnlg_pkg::OP_BATCH: state_nxt = rnlg_pkg::ST_SEL;
            default:            state_nxt = rnlg_pkg::ST_EMIT;
          endcase
        end
      end
      rnlg_pkg::ST_FIND:   if (sweep_last) state_nxt = rnlg_pkg::ST_EMIT;
      rnlg_pkg::ST_PURGE:  if (sweep_last) state_nxt = rnlg_pkg::ST_PCHK;
      rnlg_pkg::ST_PCHK:   state_nxt = overflow ? rnlg_pkg::ST_EMIT : rnlg_pkg::ST_INSERT;
      rnlg_pkg::ST_INSERT: if (SW'(d_r) == gap) state_nxt = rnlg_pkg::ST_EMIT;
      rnlg_pkg::ST_SEL:    if (sweep_last) state_nxt = rnlg_pkg::ST_UPD;
      rnlg_pkg::ST_UPD: begin
        if (!best_any_r || pend_r || last_res) begin
          state_nxt = rnlg_pkg::ST_EMIT;
        end else begin
          state_nxt = rnlg_pkg::ST_SEL;
        end
      end
      rnlg_pkg::ST_SDONE:  state_nxt = rnlg_pkg::ST_EMIT;
      rnlg_pkg::ST_EMIT:   if (out_free) state_nxt = ret_r;
      default:             state_nxt = rnlg_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    ret_nxt      = ret_r;
    seq_nxt      = seq_r;
    now_nxt      = now_r;
    started_nxt  = started_r;
    last_seq_nxt = last_seq_r;
    valid_nxt    = valid_r;
    present_nxt  = present_r;
    found_nxt    = found_r;
    count_nxt    = count_r;
    slot_nxt     = slot_r;
    d_nxt        = d_r;
    best_any_nxt = best_any_r;
    best_idx_nxt = best_idx_r;
    best_seq_nxt = best_seq_r;
    best_ret_nxt = best_ret_r;
    prev_any_nxt = prev_any_r;
    prev_nxt     = prev_r;
    nres_nxt     = nres_r;
    pend_nxt     = pend_r;
    pend_seq_nxt = pend_seq_r;
    r_rec_nxt    = r_rec_r;
    r_nv_nxt     = r_nv_r;
    r_seq_nxt    = r_seq_r;
    r_last_nxt   = r_last_r;
    ram_we       = 1'b0;
    ram_waddr    = slot_r[AW-1:0];
    ram_wdata    = '0;

    // read pipeline of the sweeps
    if (sweep_st) begin
      pv_nxt   = rd_issue;
      pidx_nxt = cnt_r[AW-1:0];
      cnt_nxt  = rd_issue ? cnt_r + CW'(1) : cnt_r;
    end else begin
      pv_nxt       = 1'b0;
      pidx_nxt     = pidx_r;
      cnt_nxt      = '0;
      best_any_nxt = 1'b0;
    end

    // result register
    out_valid_nxt = out_valid_r && !out_ready;
    o_rec_nxt     = o_rec_r;
    o_nv_nxt      = o_nv_r;
    o_seq_nxt     = o_seq_r;
    o_last_nxt    = o_last_r;

    case (state_r)
      rnlg_pkg::ST_IDLE: begin
        r_rec_nxt  = 1'b0;
        r_nv_nxt   = 1'b0;
        r_seq_nxt  = '0;
        r_last_nxt = 1'b1;
        ret_nxt    = rnlg_pkg::ST_IDLE;
        if (take) begin
          seq_nxt      = cmd.seq;
          now_nxt      = cmd.now_ms;
          found_nxt    = 1'b0;
          count_nxt    = '0;
          present_nxt  = '0;
          prev_any_nxt = 1'b0;
          nres_nxt     = '0;
          pend_nxt     = 1'b0;
          if (cmd.op == rnlg_pkg::OP_ARRIVE && !started_r) begin
            started_nxt  = 1'b1;
            last_seq_nxt = cmd.seq;
          end
          if (cmd.op == rnlg_pkg::OP_CLEAR) begin
            valid_nxt    = '0;
            started_nxt  = 1'b0;
            last_seq_nxt = '0;
          end
        end
      end
      rnlg_pkg::ST_FIND: begin
        if (hit) begin
          valid_nxt[pidx_r] = 1'b0;
          found_nxt         = 1'b1;
        end
        r_rec_nxt = found_r || hit;
      end
      rnlg_pkg::ST_PURGE: begin
        if (ent_valid) begin
          if (ent.seq < floor_seq) begin
            valid_nxt[pidx_r] = 1'b0;
          end else begin
            count_nxt = count_r + CW'(1);
            if (seq_off < SW'(TABLE_DEPTH)) begin
              present_nxt[seq_off[AW-1:0]] = 1'b1;
            end
          end
        end
      end
      rnlg_pkg::ST_PCHK: begin
        slot_nxt = '0;
        d_nxt    = '0;
        if (overflow) begin
          valid_nxt    = '0;
          last_seq_nxt = seq_r;
        end
      end
      rnlg_pkg::ST_INSERT: begin
        if (SW'(d_r) == gap) begin
          last_seq_nxt = seq_r;
        end else if (present_r[d_r[AW-1:0]]) begin
          d_nxt = d_r + CW'(1);
        end else if (valid_r[slot_r[AW-1:0]]) begin
          slot_nxt = slot_r + CW'(1);
        end else begin
          ram_we                      = 1'b1;
          ram_wdata.seq               = first_seq + SW'(d_r);
          valid_nxt[slot_r[AW-1:0]]   = 1'b1;
          slot_nxt                    = slot_r + CW'(1);
          d_nxt                       = d_r + CW'(1);
        end
      end
      rnlg_pkg::ST_SEL: begin
        if (better) begin
          best_any_nxt = 1'b1;
          best_idx_nxt = pidx_r;
          best_seq_nxt = ent.seq;
          best_ret_nxt = ent.retries;
        end
      end
      rnlg_pkg::ST_UPD: begin
        r_rec_nxt = 1'b0;
        ret_nxt   = rnlg_pkg::ST_IDLE;
        if (!best_any_r) begin
          r_nv_nxt   = pend_r;
          r_seq_nxt  = pend_r ? pend_seq_r : '0;
          r_last_nxt = 1'b1;
        end else begin
          ram_we                = 1'b1;
          ram_waddr             = best_idx_r;
          ram_wdata.seq         = best_seq_r;
          ram_wdata.retries     = ret_new;
          ram_wdata.sent_at     = now_r;
          valid_nxt[best_idx_r] = (ret_new < cfg.max_retries);
          prev_any_nxt          = 1'b1;
          prev_nxt              = best_seq_r;
          nres_nxt              = nres_r + rnlg_pkg::RES_W'(1);
          pend_nxt              = 1'b1;
          pend_seq_nxt          = best_seq_r;
          r_nv_nxt              = 1'b1;
          if (pend_r) begin
            // the earlier pick is now known not to be the final one
            r_seq_nxt  = pend_seq_r;
            r_last_nxt = 1'b0;
            ret_nxt    = last_res ? rnlg_pkg::ST_SDONE : rnlg_pkg::ST_SEL;
          end else begin
            r_seq_nxt  = best_seq_r;
            r_last_nxt = 1'b1;
          end
        end
      end
      rnlg_pkg::ST_SDONE: begin
        r_rec_nxt  = 1'b0;
        r_nv_nxt   = 1'b1;
        r_seq_nxt  = pend_seq_r;
        r_last_nxt = 1'b1;
        ret_nxt    = rnlg_pkg::ST_IDLE;
      end
      rnlg_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_rec_nxt     = r_rec_r;
          o_nv_nxt      = r_nv_r;
          o_seq_nxt     = r_seq_r;
          o_last_nxt    = r_last_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rnlg_pkg::ST_IDLE;
      ret_r       <= rnlg_pkg::ST_IDLE;
      started_r   <= 1'b0;
      last_seq_r  <= '0;
      valid_r     <= '0;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      best_any_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      started_r   <= started_nxt;
      last_seq_r  <= last_seq_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      best_any_r  <= best_any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r      <= seq_nxt;
    now_r      <= now_nxt;
    present_r  <= present_nxt;
    pidx_r     <= pidx_nxt;
    found_r    <= found_nxt;
    count_r    <= count_nxt;
    slot_r     <= slot_nxt;
    d_r        <= d_nxt;
    best_idx_r <= best_idx_nxt;
    best_seq_r <= best_seq_nxt;
    best_ret_r <= best_ret_nxt;
    prev_any_r <= prev_any_nxt;
    prev_r     <= prev_nxt;
    nres_r     <= nres_nxt;
    pend_r     <= pend_nxt;
    pend_seq_r <= pend_seq_nxt;
    r_rec_r    <= r_rec_nxt;
    r_nv_r     <= r_nv_nxt;
    r_seq_r    <= r_seq_nxt;
    r_last_r   <= r_last_nxt;
    o_rec_r    <= o_rec_nxt;
    o_nv_r     <= o_nv_nxt;
    o_seq_r    <= o_seq_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_recovered  = o_rec_r;
  assign out_nack_valid = o_nv_r;
  assign out_nack_seq   = o_seq_r;
  assign out_last       = o_last_r;

endmodule

### hw/rtl/rtp_nack_list_generator.sv
// ----------------------------------------------------------------------------
// rtp_nack_list_generator
// Missing-packet table for a 16-bit RTP sequence space with NACK batching.
// ----------------------------------------------------------------------------
// The block takes one word per handshake and gives one or more result words.
// A packet arrival (mode 0) gives one word carrying the recovered flag; a
// batch request (mode 1) gives one word per sequence number due for a NACK,
// in ascending numeric order, at most 64, with last set on the final one (or
// a single word with nack_valid low when nothing is due); a clear (mode 2) and
// the unused mode give one empty word. Timing is set by the entry table, a
// single-port-read RAM walked one entry per clock: a new or repeated first
// packet needs no walk; an older one a lookup walk; a newer one the purge
// walk, then insertion over each inserted or skipped sequence and occupied
// slot passed; a batch one walk per emitted word plus one more, unless it
// stops at 64. Valid bits are flops cleared at reset, so there is no clearing
// pass. Input words are queued two deep, so the sender can hand over the next
// word while a result waits in the output register. Registers are to be
// written only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module rtp_nack_list_generator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [rnlg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rnlg_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rnlg_pkg::MODE_W-1:0]       in_mode,
  input  logic [rnlg_pkg::SEQ_W-1:0]        in_seq,
  input  logic [rnlg_pkg::TIME_W-1:0]       in_now_ms,
  // result words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_recovered,
  output logic                              out_nack_valid,
  output logic [rnlg_pkg::SEQ_W-1:0]        out_nack_seq,
  output logic                              out_last
);

  rnlg_pkg::cfg_t cfg_r, cfg_nxt;
  rnlg_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;

  // register file: fields are truncated to their own widths
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        rnlg_pkg::CFG_RTT:     cfg_nxt.rtt_ms         = cfg_data;
        rnlg_pkg::CFG_RETRIES: cfg_nxt.max_retries    = cfg_data[rnlg_pkg::RETRY_W-1:0];
        rnlg_pkg::CFG_AGE:     cfg_nxt.max_packet_age = cfg_data;
        rnlg_pkg::CFG_ENTRIES: cfg_nxt.max_entries    = cfg_data[rnlg_pkg::ENT_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rtt_ms         <= rnlg_pkg::RST_RTT;
      cfg_r.max_retries    <= rnlg_pkg::RST_RETRIES;
      cfg_r.max_packet_age <= rnlg_pkg::RST_AGE;
      cfg_r.max_entries    <= rnlg_pkg::RST_ENTRIES;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: decode and queue
  rnlg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_seq    (in_seq),
    .in_now_ms (in_now_ms),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // back: table walks and result register
  rnlg_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_recovered  (out_recovered),
    .out_nack_valid (out_nack_valid),
    .out_nack_seq   (out_nack_seq),
    .out_last       (out_last)
  );

endmodule

### hw/rtl/rnlg_checker.sv
// ----------------------------------------------------------------------------
// rnlg_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "rtp_nack_list_generator_defines.svh"

module rnlg_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_recovered,
  input logic                       out_nack_valid,
  input logic [rnlg_pkg::SEQ_W-1:0] out_nack_seq,
  input logic                       out_last
);

  // a NACK word never reports a recovery
  `RNLG_ASSERT_NOW(a_nack_not_rec, out_valid && out_nack_valid, !out_recovered)
  // words without a NACK are always single, so they close their input
  `RNLG_ASSERT_NOW(a_empty_last, out_valid && !out_nack_valid, out_last)
  // an empty word carries sequence zero
  `RNLG_ASSERT_NOW(a_empty_seq, out_valid && !out_nack_valid, out_nack_seq == '0)
  // stalled word holds
  `RNLG_ASSERT_NEXT(a_hold, out_valid && !out_ready,
                    out_valid && $stable(out_nack_seq) && $stable(out_last))

endmodule

bind rtp_nack_list_generator rnlg_checker u_rnlg_checker (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// NACK list generator testbench
// Drives packet arrivals, batch requests and clears into the block under
// random idling, predicts every result word from a local copy of the
// missing-sequence table, and checks the words in order as they come out.
// ----------------------------------------------------------------------------

typedef struct packed {
  bit                       recovered;
  bit                       nack_valid;
  bit [rnlg_pkg::SEQ_W-1:0] nack_seq;
  bit                       last;
} nack_word_t;

class nack_scoreboard;
  localparam int DEPTH = 64;

  bit [rnlg_pkg::SEQ_W-1:0]   rtt;
  bit [rnlg_pkg::RETRY_W-1:0] retries_max;
  bit [rnlg_pkg::AGE_W-1:0]   age_max;
  bit [rnlg_pkg::ENT_W-1:0]   fill_max;

  bit                         started;
  bit [rnlg_pkg::SEQ_W-1:0]   newest;
  bit                         ent_used [DEPTH];
  bit [rnlg_pkg::SEQ_W-1:0]   ent_seq [DEPTH];
  bit [rnlg_pkg::RETRY_W-1:0] ent_tries [DEPTH];
  bit [rnlg_pkg::TIME_W-1:0]  ent_stamp [DEPTH];

  nack_word_t pending_words[$];
  int         mismatches;

  function new();
    rtt         = rnlg_pkg::RST_RTT;
    retries_max = rnlg_pkg::RST_RETRIES;
    age_max     = rnlg_pkg::RST_AGE;
    fill_max    = rnlg_pkg::RST_ENTRIES;
    forget_all();
  endfunction

  function void forget_all();
    started = 0;
    newest  = '0;
    foreach (ent_used[i]) begin
      ent_used[i] = 0; ent_seq[i] = '0; ent_tries[i] = '0; ent_stamp[i] = '0;
    end
  endfunction

  function void set_reg(logic [rnlg_pkg::CFG_IDX_W-1:0] idx,
                        logic [rnlg_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      rnlg_pkg::CFG_RTT:     rtt         = val;
      rnlg_pkg::CFG_RETRIES: retries_max = val[rnlg_pkg::RETRY_W-1:0];
      rnlg_pkg::CFG_AGE:     age_max     = val;
      rnlg_pkg::CFG_ENTRIES: fill_max    = val[rnlg_pkg::ENT_W-1:0];
      default: ;
    endcase
  endfunction

  function int slot_of(bit [rnlg_pkg::SEQ_W-1:0] s);
    for (int i = 0; i < DEPTH; i++)
      if (ent_used[i] && ent_seq[i] == s) return i;
    return -1;
  endfunction

  // wrap-aware "a is older than b"
  function bit older(bit [rnlg_pkg::SEQ_W-1:0] a, bit [rnlg_pkg::SEQ_W-1:0] b);
    bit [rnlg_pkg::SEQ_W-1:0] d;
    d = b - a;
    if (b > a && d <= 16'd32767) return 1;
    d = a - b;
    if (a > b && d > 16'd32767) return 1;
    return 0;
  endfunction

  function void open_gap(bit [rnlg_pkg::SEQ_W-1:0] s);
    bit [rnlg_pkg::SEQ_W-1:0] first, floor_s, k, gap16;
    int unsigned gap, lim, cnt;
    first   = newest + 1'b1;
    floor_s = s - age_max;
    gap16   = s - first;
    gap     = gap16;
    lim     = (fill_max < DEPTH) ? fill_max : DEPTH;
    cnt     = 0;
    foreach (ent_used[i]) if (ent_used[i] && ent_seq[i] < floor_s) ent_used[i] = 0;
    foreach (ent_used[i]) cnt += ent_used[i];
    if (cnt + gap > lim) begin
      foreach (ent_used[i]) begin
        ent_used[i] = 0; ent_seq[i] = '0; ent_tries[i] = '0; ent_stamp[i] = '0;
      end
      return;
    end
    for (k = first; k != s; k++) begin
      if (slot_of(k) >= 0) continue;
      for (int i = 0; i < DEPTH; i++)
        if (!ent_used[i]) begin
          ent_used[i] = 1; ent_seq[i] = k; ent_tries[i] = '0; ent_stamp[i] = '0;
          break;
        end
    end
  endfunction

  function bit arrive(bit [rnlg_pkg::SEQ_W-1:0] s);
    int slot;
    if (!started) begin
      started = 1; newest = s; return 0;
    end
    if (s == newest) return 0;
    if (older(s, newest)) begin
      slot = slot_of(s);
      if (slot >= 0) begin
        ent_used[slot] = 0; return 1;
      end
      return 0;
    end
    open_gap(s);
    newest = s;
    return 0;
  endfunction

  // note one accepted input word and queue the words it must produce
  function void note_word(rnlg_pkg::op_t op, bit [rnlg_pkg::SEQ_W-1:0] s,
                          bit [rnlg_pkg::TIME_W-1:0] now);
    nack_word_t w;
    int n, prev, best;
    bit [rnlg_pkg::TIME_W-1:0] since;
    w = '{0, 0, '0, 1};
    case (op)
      rnlg_pkg::OP_ARRIVE: begin
        w.recovered = arrive(s);
        pending_words.push_back(w);
      end
      rnlg_pkg::OP_BATCH: begin
        n = 0; prev = -1;
        while (n < rnlg_pkg::MAX_RESULTS) begin
          best = -1;
          for (int i = 0; i < DEPTH; i++) begin
            if (!ent_used[i] || int'(ent_seq[i]) <= prev) continue;
            since = now - ent_stamp[i];
            if (since < rtt) continue;
            if (best < 0 || ent_seq[i] < ent_seq[best]) best = i;
          end
          if (best < 0) break;
          prev = ent_seq[best];
          pending_words.push_back('{0, 1, ent_seq[best], 0});
          n++;
          if (ent_tries[best] != 8'hFF) ent_tries[best]++;
          ent_stamp[best] = now;
          if (ent_tries[best] >= retries_max) ent_used[best] = 0;
        end
        if (n == 0) pending_words.push_back(w);
        else pending_words[$].last = 1;
      end
      rnlg_pkg::OP_CLEAR: begin
        forget_all();
        pending_words.push_back(w);
      end
      default: pending_words.push_back(w);
    endcase
  endfunction

  function void check_word(nack_word_t got);
    nack_word_t want;
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word rec=%0b nv=%0b seq=%h last=%0b",
                                     got.recovered, got.nack_valid, got.nack_seq, got.last);
      return;
    end
    want = pending_words.pop_front();
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("word wrong: exp rec=%0b nv=%0b seq=%h last=%0b, got rec=%0b nv=%0b seq=%h last=%0b",
                 want.recovered, want.nack_valid, want.nack_seq, want.last,
                 got.recovered, got.nack_valid, got.nack_seq, got.last);
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = rnlg_pkg::SEQ_W;
  localparam int TW = rnlg_pkg::TIME_W;
  localparam int IW = rnlg_pkg::CFG_IDX_W;

  logic                            clk = 0;
  logic                            rst_n = 0;
  logic                            cfg_wr_en = 0;
  logic [rnlg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rnlg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 0;
  logic                            in_ready;
  logic [rnlg_pkg::MODE_W-1:0]     in_mode = '0;
  logic [SW-1:0]                   in_seq = '0;
  logic [TW-1:0]                   in_now_ms = '0;
  logic                            out_valid;
  logic                            out_ready = 0;
  logic                            out_recovered, out_nack_valid, out_last;
  logic [SW-1:0]                   out_nack_seq;

  nack_scoreboard sb = new();

  // idling percentages per phase, and the long receiver hold-off
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;

  // stimulus-side view of where the stream is
  bit [SW-1:0] cur_seq = '0;
  bit [TW-1:0] cur_now = '0;

  rtp_nack_list_generator dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("rtp_nack_list_generator: mismatch");
    $finish;
  end

  // receiver: check accepted words, then decide the next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word('{out_recovered, out_nack_valid, out_nack_seq, out_last});
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // one input word; valid stays up on return so back-to-back words work
  task automatic send(logic [rnlg_pkg::MODE_W-1:0] m, logic [SW-1:0] s, logic [TW-1:0] t);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_mode   <= m;
    in_seq    <= s;
    in_now_ms <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_word(rnlg_pkg::op_t'(m), s, t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] rtt, logic [15:0] tries, logic [15:0] age,
                            logic [15:0] fill);
    logic [15:0] vals [4];
    vals = '{rtt, tries, age, fill};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= IW'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(IW'(i), vals[i]);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic arrive(logic [SW-1:0] s);
    send(rnlg_pkg::MODE_ARRIVE, s, TW'($urandom));
    cur_seq = s;
  endtask

  task automatic nack_batch(int unsigned step);
    cur_now += step;
    send(rnlg_pkg::MODE_BATCH, SW'($urandom), cur_now);
  endtask

  // mostly an ordered stream with short gaps, some reordering and batches
  task automatic random_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50)      arrive(SW'(cur_seq + $urandom_range(1, 4)));
    else if (r < 58) send(rnlg_pkg::MODE_ARRIVE, SW'(cur_seq - $urandom_range(1, 8)),
                          TW'($urandom));
    else if (r < 85) nack_batch($urandom_range(0, 250));
    else if (r < 89) send(rnlg_pkg::MODE_CLEAR, SW'($urandom), TW'($urandom));
    else if (r < 92) send(rnlg_pkg::MODE_UNUSED, SW'($urandom), TW'($urandom));
    else if (r < 96) arrive(SW'($urandom));
    else             send(rnlg_pkg::MODE_BATCH, SW'($urandom), TW'($urandom));
  endtask

  task automatic set_idle(int unsigned ph);
    case (ph % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
      default: begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first packet, gap insertion, recovery, duplicate
    arrive(16'd0);
    arrive(16'd5);                   // sequences 1..4 go missing
    nack_batch(1000);
    send(rnlg_pkg::MODE_ARRIVE, 16'd3, '0);    // older packet in the table
    send(rnlg_pkg::MODE_ARRIVE, 16'd3, '0);    // already recovered
    arrive(16'd5);                   // repeat of the newest
    send(rnlg_pkg::MODE_ARRIVE, 16'hFFFE, '0); // far behind: counts as older
    nack_batch(50);                  // inside rtt: nothing due
    nack_batch(100);
    send(rnlg_pkg::MODE_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    // wrap of the sequence space and of the clock
    arrive(16'hFFFD);
    arrive(16'h0002);
    cur_now = 32'hFFFF_FFF0;
    nack_batch(0);
    nack_batch(32'h60);
    arrive(16'h0002 + 16'd100);      // gap above fill limit clears the table
    // full table, one batch of the maximum length
    arrive(cur_seq + 16'd65);
    nack_batch(5000);
    send(rnlg_pkg::MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send(rnlg_pkg::MODE_UNUSED, 16'h0000, 32'h0000_0000);
    nack_batch(5000);
    send(rnlg_pkg::MODE_CLEAR, '0, '0);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: ;                                         // reset values
        1: write_regs(16'd0, 16'd1, 16'd1, 16'd1);
        2: write_regs(16'hFFFF, 16'd255, 16'h8000, 16'd64);
        3: write_regs(16'd30, 16'd0, 16'd0, 16'd127);  // zero retries drops at once
        default: write_regs(16'd300, 16'd3, 16'd40, 16'd0);
      endcase
      set_idle(ph);
      if (ph == 2) begin
        // receiver holds off while the sender keeps offering words
        hold_left = 600;
        send_idle_pct = 0;
        repeat (12) random_word();
        set_idle(ph);
      end
      repeat (20) random_word();
      drain();                       // sender waits for every result
      repeat (20) random_word();
    end

    drain();
    repeat (5000) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_words.size() == 0)
      $display("rtp_nack_list_generator: match");
    else
      $display("rtp_nack_list_generator: mismatch");
    $finish;
  end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/rnlg_pkg.sv
hw/rtl/rnlg_ram.sv
hw/rtl/rnlg_front.sv
hw/rtl/rnlg_back.sv
hw/rtl/rtp_nack_list_generator.sv
hw/rtl/rnlg_checker.sv
tb/testbench.sv
